/* rtl/bdpia_pkg.sv */
`default_nettype none
package bdpia_pkg;

  typedef enum logic [2:0] {
    OP_READ  = 3'd0,
    OP_WRITE = 3'd1,
    OP_DUMMY = 3'd2,
    OP_POLL  = 3'd3,
    OP_LOAD  = 3'd4
  } opcode_t;

  typedef enum logic [0:0] {
    CFG_MEM_BYTES  = 1'b0,
    CFG_DIRECT_MAP = 1'b1
  } cfg_index_t;

  typedef enum logic [1:0] {
    RGN_NONE = 2'd0,
    RGN_RAM  = 2'd1,
    RGN_ROM  = 2'd2,
    RGN_PIA  = 2'd3
  } region_t;

  typedef enum logic [1:0] {
    PIA_KBD_DATA = 2'd0,
    PIA_KBD_CTRL = 2'd1,
    PIA_DSP_DATA = 2'd2,
    PIA_DSP_CTRL = 2'd3
  } pia_reg_t;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_READ  = 3'b100
  } state_t;

  typedef struct packed {
    region_t     region;
    logic [15:0] ram_idx;
    logic [7:0]  rom_off;
    pia_reg_t    reg_sel;
  } dec_t;

  typedef struct packed {
    logic     rd;
    logic     wr;
    logic     dummy;
    logic     poll;
    pia_reg_t reg_sel;
  } pia_req_t;

  typedef struct packed {
    logic [7:0] rd_data;
    logic       disp_valid;
    logic [7:0] disp_byte;
    logic       key_taken;
  } pia_rsp_t;

  localparam int          ROM_DEPTH     = 256;
  localparam logic [16:0] SPLIT_SIZE    = 17'd8192;
  localparam logic [16:0] MEM_BYTES_RST = 17'd8192;
  localparam logic [15:0] BANK_LO_END   = 16'h1000;
  localparam logic [15:0] BANK_HI_BASE  = 16'hE000;
  localparam logic [15:0] BANK_HI_END   = 16'hF000;
  localparam logic [15:0] BANK_HI_SHIFT = 16'hD000;
  localparam logic [3:0]  PIA_PAGE      = 4'hD;
  localparam int          CTRL_STROBE   = 7;
  localparam int          CTRL_ENABLE   = 2;
  localparam logic [7:0]  DISP_CTRL_RST = 8'h80;

endpackage
`default_nettype wire

/* rtl/bdpia_ram.sv */
`default_nettype none
module bdpia_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

/* rtl/bdpia_decode.sv */
`default_nettype none
module bdpia_decode
  import bdpia_pkg::*;
#(
  parameter int RAM_BYTES = 65536,
  parameter int PIA_ADDR  = 53264,
  parameter int ROM_ADDR  = 65280
) (
  input  wire logic [15:0] address,
  input  wire logic [16:0] mem_bytes,
  input  wire logic        direct_map,
  output dec_t             dec
);

  localparam logic [16:0] RamLimit = 17'(RAM_BYTES);
  localparam logic [15:0] PiaBase  = 16'(PIA_ADDR);
  localparam logic [16:0] PiaTop   = 17'(PIA_ADDR + 3);
  localparam logic [15:0] RomBase  = 16'(ROM_ADDR);

  logic        split;
  logic [15:0] alias_addr;
  logic [15:0] flat_idx;
  logic [15:0] dec_idx;
  logic        flat_hit;
  logic        dec_hit;
  logic        in_hi_bank;

  // upper split window maps onto store entries 1000-1fff
  function automatic logic [15:0] bank_index(input logic [15:0] a, input logic sp);
    if (sp && a >= BANK_HI_BASE && a < BANK_HI_END) begin
      return a - BANK_HI_SHIFT;
    end
    return a;
  endfunction

  always_comb begin
    split      = (mem_bytes == SPLIT_SIZE);
    flat_idx   = bank_index(address, split);
    flat_hit   = ({1'b0, flat_idx} < mem_bytes) && ({1'b0, flat_idx} < RamLimit);

    // whole d000-dfff page folds onto the four pia registers
    alias_addr = (address[15:12] == PIA_PAGE) ? (PiaBase | {14'b0, address[1:0]}) : address;
    dec_idx    = bank_index(alias_addr, split);
    in_hi_bank = (alias_addr >= BANK_HI_BASE) && (alias_addr < BANK_HI_END);
    dec_hit    = (split ? (alias_addr < BANK_LO_END || in_hi_bank)
                        : ({1'b0, alias_addr} < mem_bytes))
                 && ({1'b0, dec_idx} < RamLimit);

    dec.rom_off = alias_addr[7:0] - RomBase[7:0];
    dec.reg_sel = pia_reg_t'(alias_addr[1:0] - PiaBase[1:0]);
    if (direct_map) begin
      dec.ram_idx = flat_idx;
      dec.region  = flat_hit ? RGN_RAM : RGN_NONE;
    end else begin
      dec.ram_idx = dec_idx;
      if (alias_addr >= RomBase) begin
        dec.region = RGN_ROM;
      end else if (alias_addr >= PiaBase && {1'b0, alias_addr} <= PiaTop) begin
        dec.region = RGN_PIA;
      end else if (dec_hit) begin
        dec.region = RGN_RAM;
      end else begin
        dec.region = RGN_NONE;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/bdpia_pia.sv */
`default_nettype none
module bdpia_pia
  import bdpia_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  pia_req_t        req,
  input  wire logic [7:0] write_data,
  input  wire logic       display_ready,
  input  wire logic       key_available,
  input  wire logic [7:0] key_code,
  output pia_rsp_t        rsp
);

  logic [7:0] key_latch_r, key_latch_nxt;
  logic [7:0] key_ctrl_r, key_ctrl_nxt;
  logic [7:0] disp_latch_r, disp_latch_nxt;
  logic [7:0] disp_ctrl_r, disp_ctrl_nxt;

  always_comb begin
    key_latch_nxt  = key_latch_r;
    key_ctrl_nxt   = key_ctrl_r;
    disp_latch_nxt = disp_latch_r;
    disp_ctrl_nxt  = disp_ctrl_r;
    rsp            = '0;

    case (req.reg_sel)
      PIA_KBD_DATA: rsp.rd_data = key_ctrl_r[CTRL_ENABLE] ? key_latch_r : 8'h00;
      PIA_KBD_CTRL: rsp.rd_data = key_ctrl_r;
      PIA_DSP_DATA: rsp.rd_data = {~display_ready, disp_latch_r[6:0]};
      PIA_DSP_CTRL: rsp.rd_data = {display_ready, disp_ctrl_r[6:0]};
      default:      rsp.rd_data = 8'h00;
    endcase

    // reading keyboard data clears the strobe while the enable bit is set
    if (req.rd && req.reg_sel == PIA_KBD_DATA && key_ctrl_r[CTRL_ENABLE]) begin
      key_ctrl_nxt[CTRL_STROBE] = 1'b0;
    end

    if (req.wr) begin
      case (req.reg_sel)
        PIA_KBD_CTRL: begin
          if (req.dummy) begin
            key_ctrl_nxt[CTRL_STROBE] = 1'b0;
          end else begin
            key_ctrl_nxt = {key_ctrl_r[7], write_data[6:0]};
          end
        end
        PIA_DSP_DATA: begin
          if (disp_ctrl_r[CTRL_ENABLE]) begin
            if (req.dummy) begin
              disp_ctrl_nxt[CTRL_STROBE] = 1'b1;
            end else begin
              disp_latch_nxt = write_data;
              rsp.disp_valid = 1'b1;
              rsp.disp_byte  = write_data;
            end
          end
        end
        PIA_DSP_CTRL: disp_ctrl_nxt = {disp_ctrl_r[7], write_data[6:0]};
        default: ;
      endcase
    end

    if (req.poll && !key_ctrl_r[CTRL_STROBE] && key_available && key_code != 8'h00) begin
      key_latch_nxt             = key_code;
      key_ctrl_nxt[CTRL_STROBE] = 1'b1;
      rsp.key_taken             = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_latch_r  <= 8'h00;
      key_ctrl_r   <= 8'h00;
      disp_latch_r <= 8'h00;
      disp_ctrl_r  <= DISP_CTRL_RST;
    end else begin
      key_latch_r  <= key_latch_nxt;
      key_ctrl_r   <= key_ctrl_nxt;
      disp_latch_r <= disp_latch_nxt;
      disp_ctrl_r  <= disp_ctrl_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/bus_decoder_with_pia_terminal_core.sv */
// channel  | direction | handshake             | payload
// ---------+-----------+-----------------------+------------------------------------------
// in_      | input     | in_valid / in_stall   | opcode, address, write_data, display_ready,
//          |           |                       | key_available, key_code
// out_     | output    | out_valid / out_stall | read_data, display_valid, display_byte,
//          |           |                       | key_taken
// cfg_     | input     | cfg_wr_en             | cfg_index, cfg_data
//
// a read that reaches ram or loaded rom goes through the registered memory read and ST_READ
// before its result is registered; every other item's result is registered as it is accepted.
// after reset the ram is swept to zero over all RAM_BYTES entries (65536 by default), with in_stall
// high; configuration writes are taken throughout.
// one output register holds a finished item; in_stall stays high while it is held by out_stall.
`default_nettype none
module bus_decoder_with_pia_terminal_core
  import bdpia_pkg::*;
#(
  parameter int RAM_BYTES = 65536,
  parameter int PIA_ADDR  = 53264,
  parameter int ROM_ADDR  = 65280
) (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        cfg_wr_en,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [16:0] cfg_data,

  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_opcode,
  input  wire logic [15:0] in_address,
  input  wire logic [7:0]  in_write_data,
  input  wire logic        in_display_ready,
  input  wire logic        in_key_available,
  input  wire logic [7:0]  in_key_code,

  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_read_data,
  output logic             out_display_valid,
  output logic [7:0]       out_display_byte,
  output logic             out_key_taken
);

  localparam int          AW      = $clog2(RAM_BYTES);
  localparam logic [AW-1:0] LastIdx = AW'(RAM_BYTES - 1);

  state_t        state_r, state_nxt;
  logic [AW-1:0] clr_addr_r, clr_addr_nxt;
  logic [16:0]   mem_bytes_r;
  logic          direct_map_r;
  logic          rom_valid_r, rom_valid_nxt;
  logic [7:0]    open_bus_r, open_bus_nxt;
  logic          rd_rom_r, rd_rom_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_read_data_r, out_read_data_nxt;
  logic          out_display_valid_r, out_display_valid_nxt;
  logic [7:0]    out_display_byte_r, out_display_byte_nxt;
  logic          out_key_taken_r, out_key_taken_nxt;

  dec_t          dec;
  pia_req_t      pia_req;
  pia_rsp_t      pia_rsp;

  logic          in_acc;
  logic          op_rd;
  logic          op_wr;
  logic          mem_rd;
  logic          ram_wr_en;
  logic [AW-1:0] ram_wr_addr;
  logic [7:0]    ram_wr_data;
  logic [7:0]    ram_rd_data;
  logic          rom_wr_en;
  logic [7:0]    rom_rd_data;
  logic [7:0]    mem_data;

  bdpia_decode #(
    .RAM_BYTES(RAM_BYTES),
    .PIA_ADDR (PIA_ADDR),
    .ROM_ADDR (ROM_ADDR)
  ) u_decode (
    .address   (in_address),
    .mem_bytes (mem_bytes_r),
    .direct_map(direct_map_r),
    .dec       (dec)
  );

  bdpia_pia u_pia (
    .clk          (clk),
    .rst_n        (rst_n),
    .req          (pia_req),
    .write_data   (in_write_data),
    .display_ready(in_display_ready),
    .key_available(in_key_available),
    .key_code     (in_key_code),
    .rsp          (pia_rsp)
  );

  bdpia_ram #(
    .WIDTH(8),
    .DEPTH(RAM_BYTES)
  ) u_ram (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data),
    .rd_addr(dec.ram_idx[AW-1:0]),
    .rd_data(ram_rd_data)
  );

  bdpia_ram #(
    .WIDTH(8),
    .DEPTH(ROM_DEPTH)
  ) u_rom (
    .clk    (clk),
    .wr_en  (rom_wr_en),
    .wr_addr(in_address[7:0]),
    .wr_data(in_write_data),
    .rd_addr(dec.rom_off),
    .rd_data(rom_rd_data)
  );

  assign in_stall = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign in_acc   = in_valid && !in_stall;
  assign op_rd    = (in_opcode == OP_READ);
  assign op_wr    = (in_opcode == OP_WRITE) || (in_opcode == OP_DUMMY);
  assign mem_rd   = op_rd && ((dec.region == RGN_RAM)
                              || (dec.region == RGN_ROM && rom_valid_r));
  assign mem_data = rd_rom_r ? rom_rd_data : ram_rd_data;

  always_comb begin
    pia_req.rd      = in_acc && op_rd && dec.region == RGN_PIA;
    pia_req.wr      = in_acc && op_wr && dec.region == RGN_PIA;
    pia_req.dummy   = (in_opcode == OP_DUMMY);
    pia_req.poll    = in_acc && in_opcode == OP_POLL;
    pia_req.reg_sel = dec.reg_sel;

    // clear sweep owns the write port until it finishes
    if (state_r == ST_CLEAR) begin
      ram_wr_en   = 1'b1;
      ram_wr_addr = clr_addr_r;
      ram_wr_data = 8'h00;
    end else begin
      ram_wr_en   = in_acc && op_wr && dec.region == RGN_RAM;
      ram_wr_addr = dec.ram_idx[AW-1:0];
      ram_wr_data = in_write_data;
    end
    rom_wr_en = in_acc && in_opcode == OP_LOAD;
  end

  always_comb begin
    state_nxt             = state_r;
    clr_addr_nxt          = clr_addr_r;
    rom_valid_nxt         = rom_valid_r;
    open_bus_nxt          = open_bus_r;
    rd_rom_nxt            = rd_rom_r;
    out_valid_nxt         = out_valid_r && out_stall;
    out_read_data_nxt     = out_read_data_r;
    out_display_valid_nxt = out_display_valid_r;
    out_display_byte_nxt  = out_display_byte_r;
    out_key_taken_nxt     = out_key_taken_r;

    case (state_r)
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == LastIdx) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          if (in_opcode == OP_LOAD) begin
            rom_valid_nxt = 1'b1;
          end
          if (op_wr) begin
            open_bus_nxt = in_write_data;
          end
          if (mem_rd) begin
            rd_rom_nxt = (dec.region == RGN_ROM);
            state_nxt  = ST_READ;
          end else begin
            out_valid_nxt         = 1'b1;
            out_display_valid_nxt = pia_rsp.disp_valid;
            out_display_byte_nxt  = pia_rsp.disp_byte;
            out_key_taken_nxt     = pia_rsp.key_taken;
            out_read_data_nxt     = 8'h00;
            if (pia_req.rd) begin
              open_bus_nxt      = pia_rsp.rd_data;
              out_read_data_nxt = pia_rsp.rd_data;
            end else if (op_rd) begin
              out_read_data_nxt = open_bus_r;
            end
          end
        end
      end
      ST_READ: begin
        // output slot was emptied when this item was accepted
        open_bus_nxt          = mem_data;
        out_valid_nxt         = 1'b1;
        out_read_data_nxt     = mem_data;
        out_display_valid_nxt = 1'b0;
        out_display_byte_nxt  = 8'h00;
        out_key_taken_nxt     = 1'b0;
        state_nxt             = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_addr_r   <= '0;
      mem_bytes_r  <= MEM_BYTES_RST;
      direct_map_r <= 1'b0;
      rom_valid_r  <= 1'b0;
      open_bus_r   <= 8'h00;
      rd_rom_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      rom_valid_r <= rom_valid_nxt;
      open_bus_r  <= open_bus_nxt;
      rd_rom_r    <= rd_rom_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_MEM_BYTES:  mem_bytes_r  <= cfg_data;
          CFG_DIRECT_MAP: direct_map_r <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    out_read_data_r     <= out_read_data_nxt;
    out_display_valid_r <= out_display_valid_nxt;
    out_display_byte_r  <= out_display_byte_nxt;
    out_key_taken_r     <= out_key_taken_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_read_data     = out_read_data_r;
  assign out_display_valid = out_display_valid_r;
  assign out_display_byte  = out_display_byte_r;
  assign out_key_taken     = out_key_taken_r;

  a_read_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_READ |=> state_r == ST_IDLE)
    else $error("memory read did not complete in one cycle");

  a_read_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_READ |-> !out_valid_r)
    else $error("output register busy while memory read returns");

  a_write_drives_bus: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && op_wr |=> open_bus_r == $past(in_write_data))
    else $error("open bus latch missed a written byte");

endmodule
`default_nettype wire

/* bench/bus_decoder_with_pia_terminal_core_checker.sv */
`timescale 1ns / 100ps
module bus_decoder_with_pia_terminal_core_checker
  import bdpia_pkg::*;
#(
  parameter int RAM_BYTES = 65536,
  parameter int PIA_ADDR  = 53264,
  parameter int ROM_ADDR  = 65280
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [0:0]  cfg_index,
  input  logic [16:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  in_opcode,
  input  logic [15:0] in_address,
  input  logic [7:0]  in_write_data,
  input  logic        in_display_ready,
  input  logic        in_key_available,
  input  logic [7:0]  in_key_code,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_read_data,
  input  logic        out_display_valid,
  input  logic [7:0]  out_display_byte,
  input  logic        out_key_taken,
  output int          result_errors,
  output int          results_due
);

  typedef struct packed {
    logic [7:0] read_data;
    logic       display_valid;
    logic [7:0] display_byte;
    logic       key_taken;
  } bus_result_t;

  // shadow of the bus and pia state
  logic [7:0]  ram_img [RAM_BYTES];
  logic [7:0]  rom_img [ROM_DEPTH];
  logic        rom_filled;
  logic [7:0]  bus_latch;
  logic [7:0]  kbd_latch;
  logic [7:0]  kbd_ctrl;
  logic [7:0]  dsp_latch;
  logic [7:0]  dsp_ctrl;
  logic [16:0] mem_bytes_q;
  logic        flat_q;

  bus_result_t awaited_results [$];

  function automatic logic ram_lookup(input int unsigned a, output int unsigned idx);
    logic split;
    logic decoded;
    split = (mem_bytes_q == SPLIT_SIZE);
    idx = (split && a >= BANK_HI_BASE && a < BANK_HI_END) ? a - BANK_HI_SHIFT : a;
    if (flat_q) begin
      decoded = idx < mem_bytes_q;
    end else if (split) begin
      decoded = a < BANK_LO_END || (a >= BANK_HI_BASE && a < BANK_HI_END);
    end else begin
      decoded = a < mem_bytes_q;
    end
    return decoded && idx < RAM_BYTES;
  endfunction

  // the whole d page folds onto the four pia registers
  function automatic int unsigned unalias(input logic [15:0] a);
    if (a[15:12] == PIA_PAGE) return (PIA_ADDR | a[1:0]) & 'hFFFF;
    return a;
  endfunction

  function automatic logic [7:0] pia_fetch(input pia_reg_t sel, input logic ready);
    case (sel)
      PIA_KBD_DATA: begin
        if (!kbd_ctrl[CTRL_ENABLE]) return 8'h00;
        kbd_ctrl[CTRL_STROBE] = 1'b0;
        return kbd_latch;
      end
      PIA_KBD_CTRL: return kbd_ctrl;
      PIA_DSP_DATA: return {~ready, dsp_latch[6:0]};
      default:      return {ready, dsp_ctrl[6:0]};
    endcase
  endfunction

  // returns 1 when the byte went out to the display
  function automatic logic pia_store(input pia_reg_t sel, input logic [7:0] v,
                                     input logic dummy);
    case (sel)
      PIA_KBD_CTRL: begin
        if (dummy) kbd_ctrl[CTRL_STROBE] = 1'b0;
        else kbd_ctrl[6:0] = v[6:0];
      end
      PIA_DSP_DATA: begin
        if (dsp_ctrl[CTRL_ENABLE]) begin
          if (dummy) begin
            dsp_ctrl[CTRL_STROBE] = 1'b1;
          end else begin
            dsp_latch = v;
            return 1'b1;
          end
        end
      end
      PIA_DSP_CTRL: dsp_ctrl[6:0] = v[6:0];
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic bus_result_t bus_access(input logic [2:0] op, input logic [15:0] addr,
                                             input logic [7:0] wd, input logic ready,
                                             input logic avail, input logic [7:0] key);
    bus_result_t r;
    int unsigned a;
    int unsigned idx;
    r = '0;
    a = addr;
    case (op)
      OP_READ: begin
        if (flat_q) begin
          if (ram_lookup(a, idx)) bus_latch = ram_img[idx];
        end else begin
          a = unalias(addr);
          if (a >= ROM_ADDR) begin
            if (rom_filled) bus_latch = rom_img[8'(a - ROM_ADDR)];
          end else if (a >= PIA_ADDR && a <= PIA_ADDR + 3) begin
            bus_latch = pia_fetch(pia_reg_t'(2'(a - PIA_ADDR)), ready);
          end else if (ram_lookup(a, idx)) begin
            bus_latch = ram_img[idx];
          end
        end
        r.read_data = bus_latch;
      end
      OP_WRITE, OP_DUMMY: begin
        bus_latch = wd;
        if (flat_q) begin
          if (ram_lookup(a, idx)) ram_img[idx] = wd;
        end else begin
          a = unalias(addr);
          if (a < ROM_ADDR) begin
            if (a >= PIA_ADDR && a <= PIA_ADDR + 3) begin
              r.display_valid = pia_store(pia_reg_t'(2'(a - PIA_ADDR)), wd, op == OP_DUMMY);
              if (r.display_valid) r.display_byte = wd;
            end else if (ram_lookup(a, idx)) begin
              ram_img[idx] = wd;
            end
          end
        end
      end
      OP_POLL: begin
        if (!kbd_ctrl[CTRL_STROBE] && avail && key != 8'h00) begin
          kbd_latch = key;
          kbd_ctrl[CTRL_STROBE] = 1'b1;
          r.key_taken = 1'b1;
        end
      end
      OP_LOAD: begin
        rom_img[addr[7:0]] = wd;
        rom_filled = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic int field_differs(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
    if (got === want) return 0;
    $error("%s: expected %0h, actual %0h", name, want, got);
    return 1;
  endfunction

  always @(posedge clk) begin
    bus_result_t want;
    bus_result_t got;
    int errs;
    errs = 0;
    if (!rst_n) begin
      foreach (ram_img[i]) ram_img[i] = 8'h00;
      foreach (rom_img[i]) rom_img[i] = 8'h00;
      rom_filled = 1'b0;
      bus_latch = 8'h00;
      kbd_latch = 8'h00;
      kbd_ctrl = 8'h00;
      dsp_latch = 8'h00;
      dsp_ctrl = DISP_CTRL_RST;
      mem_bytes_q = MEM_BYTES_RST;
      flat_q = 1'b0;
      awaited_results.delete();
      result_errors <= 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_MEM_BYTES:  mem_bytes_q = cfg_data;
          CFG_DIRECT_MAP: flat_q = cfg_data[0];
          default: ;
        endcase
      end
      // results first, so an item can never match its own result in the same cycle
      if (out_valid && !out_stall) begin
        got = {out_read_data, out_display_valid, out_display_byte, out_key_taken};
        if (awaited_results.size() == 0) begin
          $error("result arrived with nothing outstanding");
          errs++;
        end else begin
          want = awaited_results.pop_front();
          errs += field_differs("read_data", want.read_data, got.read_data);
          errs += field_differs("display_valid", want.display_valid, got.display_valid);
          errs += field_differs("display_byte", want.display_byte, got.display_byte);
          errs += field_differs("key_taken", want.key_taken, got.key_taken);
        end
      end
      if (in_valid && !in_stall) begin
        awaited_results.push_back(bus_access(in_opcode, in_address, in_write_data,
                                             in_display_ready, in_key_available,
                                             in_key_code));
      end
      result_errors <= result_errors + errs;
    end
    results_due <= awaited_results.size();
  end

endmodule

/* bench/bus_decoder_with_pia_terminal_core_tb.sv */
`timescale 1ns / 100ps
module bus_decoder_with_pia_terminal_core_tb;
  import bdpia_pkg::*;

  localparam int RAM_BYTES      = 65536;
  localparam int PIA_ADDR       = 53264;
  localparam int ROM_ADDR       = 65280;
  localparam int CLK_HALF       = 5;
  localparam int PHASE_ITEMS    = 92;
  localparam int NUM_PHASES     = 9;
  localparam int HOLD_CYCLES    = 60;
  localparam int DRAIN_CYCLES   = 16;
  // the ram sweep after reset is the longest quiet stretch of a good run
  localparam int WATCHDOG_LIMIT = 3 * RAM_BYTES + 1000;

  localparam logic [2:0] OP_UNUSED_LO = 3'd5;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;

  localparam logic [16:0] PHASE_SIZE [NUM_PHASES] =
    '{17'd8192, 17'd65536, 17'd0, 17'd4096, 17'd65536, 17'd0, 17'd8192, 17'd40000, 17'd8192};
  localparam logic PHASE_FLAT [NUM_PHASES] =
    '{1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0};
  localparam int GAP_PCT   [4] = '{0, 78, 0, 26};
  localparam int STALL_PCT [4] = '{0, 0, 78, 26};

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] addr;
    logic [7:0]  data;
    logic        ready;
    logic        avail;
    logic [7:0]  key;
  } bus_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [0:0]  cfg_index = CFG_MEM_BYTES;
  logic [16:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_opcode = '0;
  logic [15:0] in_address = '0;
  logic [7:0]  in_write_data = '0;
  logic        in_display_ready = 1'b0;
  logic        in_key_available = 1'b0;
  logic [7:0]  in_key_code = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_read_data;
  logic        out_display_valid;
  logic [7:0]  out_display_byte;
  logic        out_key_taken;

  int result_errors;
  int results_due;

  int          gap_pct = 0;
  int          stall_pct = 0;
  logic        long_hold_req = 1'b0;
  logic [16:0] cur_mem_bytes = MEM_BYTES_RST;
  logic        cur_flat = 1'b0;
  bit          rom_written [ROM_DEPTH];
  logic [7:0]  loaded_offs [$];

  always #CLK_HALF clk = ~clk;

  bus_decoder_with_pia_terminal_core #(
    .RAM_BYTES(RAM_BYTES),
    .PIA_ADDR (PIA_ADDR),
    .ROM_ADDR (ROM_ADDR)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_address       (in_address),
    .in_write_data    (in_write_data),
    .in_display_ready (in_display_ready),
    .in_key_available (in_key_available),
    .in_key_code      (in_key_code),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_read_data    (out_read_data),
    .out_display_valid(out_display_valid),
    .out_display_byte (out_display_byte),
    .out_key_taken    (out_key_taken)
  );

  bus_decoder_with_pia_terminal_core_checker #(
    .RAM_BYTES(RAM_BYTES),
    .PIA_ADDR (PIA_ADDR),
    .ROM_ADDR (ROM_ADDR)
  ) u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_address       (in_address),
    .in_write_data    (in_write_data),
    .in_display_ready (in_display_ready),
    .in_key_available (in_key_available),
    .in_key_code      (in_key_code),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_read_data    (out_read_data),
    .out_display_valid(out_display_valid),
    .out_display_byte (out_display_byte),
    .out_key_taken    (out_key_taken),
    .result_errors    (result_errors),
    .results_due      (results_due)
  );

  function automatic bus_item_t bus_op(input logic [2:0] op, input logic [15:0] addr,
                                       input logic [7:0] data, input logic ready,
                                       input logic avail, input logic [7:0] key);
    return '{op: op, addr: addr, data: data, ready: ready, avail: avail, key: key};
  endfunction

  // small windows so that reads find earlier writes, plus the decode edges
  function automatic logic [15:0] pick_address();
    case ($urandom_range(0, 8))
      0: return 16'(PIA_ADDR + $urandom_range(0, 3));
      1: return {PIA_PAGE, 12'($urandom)};
      2: return 16'($urandom_range(0, 15));
      3: return BANK_LO_END - 16'd8 + 16'($urandom_range(0, 15));
      4: return BANK_HI_BASE + 16'($urandom_range(0, 15));
      5: return BANK_HI_END - 16'd8 + 16'($urandom_range(0, 15));
      6: return 16'(cur_mem_bytes - 17'd8 + 17'($urandom_range(0, 15)));
      7: return 16'(ROM_ADDR + $urandom_range(0, 255));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic bus_item_t random_bus_op();
    bus_item_t it;
    int unsigned pick;
    it.addr = pick_address();
    it.data = 8'($urandom);
    it.ready = 1'($urandom);
    it.avail = ($urandom_range(0, 3) != 0);
    it.key = ($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 34) it.op = OP_READ;
    else if (pick < 56) it.op = OP_WRITE;
    else if (pick < 64) it.op = OP_DUMMY;
    else if (pick < 80) it.op = OP_POLL;
    else if (pick < 92) it.op = OP_LOAD;
    else it.op = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
    // pia page writes mostly turn the enable bit on, so data paths open up
    if (it.op == OP_WRITE && it.addr[15:12] == PIA_PAGE && $urandom_range(0, 3) != 0)
      it.data[CTRL_ENABLE] = 1'b1;
    return it;
  endfunction

  task automatic send_item(input bus_item_t it);
    // once the rom holds anything, reads stay on loaded entries
    if (it.op == OP_READ && !cur_flat && it.addr[15:12] != PIA_PAGE && it.addr >= ROM_ADDR
        && loaded_offs.size() != 0 && !rom_written[8'(it.addr - ROM_ADDR)])
      it.addr = 16'(ROM_ADDR) + loaded_offs[$urandom_range(0, loaded_offs.size() - 1)];
    if (it.op == OP_LOAD && !rom_written[it.addr[7:0]]) begin
      rom_written[it.addr[7:0]] = 1'b1;
      loaded_offs.push_back(it.addr[7:0]);
    end
    if ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < gap_pct);
    end
    in_valid         <= 1'b1;
    in_opcode        <= it.op;
    in_address       <= it.addr;
    in_write_data    <= it.data;
    in_display_ready <= it.ready;
    in_key_available <= it.avail;
    in_key_code      <= it.key;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic configure(input logic [16:0] size, input logic flat);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_MEM_BYTES;
    cfg_data  <= size;
    @(posedge clk);
    cfg_index <= CFG_DIRECT_MAP;
    cfg_data  <= 17'(flat);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_mem_bytes = size;
    cur_flat = flat;
  endtask

  initial begin : receiver
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    int phase;
    int n;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    // taken while the ram is still being swept
    configure(MEM_BYTES_RST, 1'b0);

    // rom before any load reads the open bus
    send_item(bus_op(OP_READ, 16'(ROM_ADDR), 8'h00, 1'b1, 1'b0, 8'h00));
    send_item(bus_op(OP_WRITE, 16'h0000, 8'hA5, 1'b1, 1'b0, 8'h00));
    send_item(bus_op(OP_READ, 16'h0000, 8'h00, 1'b0, 1'b1, 8'hFF));
    // split mode: upper bank and the hole between the banks
    send_item(bus_op(OP_WRITE, BANK_HI_BASE, 8'h5A, 1'b1, 1'b0, 8'h00));
    send_item(bus_op(OP_READ, BANK_HI_BASE, 8'h00, 1'b1, 1'b0, 8'h00));
    send_item(bus_op(OP_READ, BANK_LO_END, 8'h00, 1'b1, 1'b0, 8'h00));
    // rom window ignores writes, but the bus latch takes the byte
    send_item(bus_op(OP_WRITE, 16'hFFFF, 8'hFF, 1'b1, 1'b0, 8'h00));
    send_item(bus_op(OP_READ, 16'h8000, 8'h00, 1'b1, 1'b0, 8'h00));
    send_item(bus_op(OP_LOAD, 16'h12FF, 8'h3C, 1'b1, 1'b0, 8'h00));
    send_item(bus_op(OP_LOAD, 16'hAB00, 8'hC3, 1'b1, 1'b0, 8'h00));
    send_item(bus_op(OP_READ, 16'hFFFF, 8'h00, 1'b1, 1'b0, 8'h00));
    send_item(bus_op(OP_READ, 16'(ROM_ADDR), 8'h00, 1'b1, 1'b0, 8'h00));
    // keyboard: enable, zero key ignored, take a key, strobe blocks the next
    send_item(bus_op(OP_WRITE, 16'(PIA_ADDR + PIA_KBD_CTRL), 8'hFF, 1'b1, 1'b0, 8'h00));
    send_item(bus_op(OP_POLL, 16'h0000, 8'h00, 1'b1, 1'b1, 8'h00));
    send_item(bus_op(OP_POLL, 16'hFFFF, 8'hFF, 1'b0, 1'b1, 8'hFF));
    send_item(bus_op(OP_POLL, 16'h0000, 8'h00, 1'b1, 1'b1, 8'h42));
    send_item(bus_op(OP_READ, 16'(PIA_ADDR + PIA_KBD_CTRL), 8'h00, 1'b1, 1'b0, 8'h00));
    // aliased data read clears the strobe
    send_item(bus_op(OP_READ, {PIA_PAGE, 12'hFFC}, 8'h00, 1'b1, 1'b0, 8'h00));
    send_item(bus_op(OP_POLL, 16'h0000, 8'h00, 1'b1, 1'b1, 8'h80));
    send_item(bus_op(OP_DUMMY, 16'(PIA_ADDR + PIA_KBD_CTRL), 8'h00, 1'b1, 1'b0, 8'h00));
    // display: sent even while the terminal is not ready
    send_item(bus_op(OP_WRITE, 16'(PIA_ADDR + PIA_DSP_CTRL), 8'h04, 1'b1, 1'b0, 8'h00));
    send_item(bus_op(OP_WRITE, 16'(PIA_ADDR + PIA_DSP_DATA), 8'h8D, 1'b0, 1'b0, 8'h00));
    send_item(bus_op(OP_READ, 16'(PIA_ADDR + PIA_DSP_DATA), 8'h00, 1'b0, 1'b0, 8'h00));
    send_item(bus_op(OP_DUMMY, 16'(PIA_ADDR + PIA_DSP_DATA), 8'h11, 1'b1, 1'b0, 8'h00));
    send_item(bus_op(OP_READ, 16'(PIA_ADDR + PIA_DSP_CTRL), 8'h00, 1'b1, 1'b0, 8'h00));
    send_item(bus_op(OP_UNUSED_HI, 16'hFFFF, 8'hFF, 1'b1, 1'b1, 8'hFF));

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      drain_results();
      configure(PHASE_SIZE[phase], PHASE_FLAT[phase]);
      gap_pct = GAP_PCT[phase % 4];
      stall_pct = STALL_PCT[phase % 4];
      for (n = 0; n < PHASE_ITEMS; n++) begin
        // long receiver hold while items keep coming fills the block up
        if (n == 20 && gap_pct == 0) long_hold_req = 1'b1;
        send_item(random_bus_op());
      end
    end

    stall_pct = 0;
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (result_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
